// ----- rtl/owbm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_pkg
// Shared types and constants of the single-wire bus master.
// ----------------------------------------------------------------------------
package owbm_pkg;

    localparam int BYTE_BITS        = 8;
    localparam int TICK_COUNT_WIDTH = 16;
    localparam int BIT_IDX_W        = 3;
    localparam int CFG_ADDR_W       = 5;
    localparam int CFG_DATA_W       = 32;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_POLL,
        PH_WR_SETUP,
        PH_WR_ZERO,
        PH_WR_GAP,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_SAMPLE,
        PH_RD_REC
    } phase_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_RESET,
        OP_WRITE,
        OP_READ
    } op_t;

    typedef enum logic [2:0] {
        REG_RESET_LOW,
        REG_PRESENCE_POLLS,
        REG_WRITE_SETUP,
        REG_WRITE_ZERO,
        REG_READ_LOW,
        REG_READ_SAMPLE,
        REG_READ_RECOVERY,
        REG_BYTE_GAP
    } reg_idx_t;

    localparam logic [15:0] RST_RESET_LOW     = 16'd100;
    localparam logic [7:0]  RST_PRESENCE_POLL = 8'd40;
    localparam logic [15:0] RST_WRITE_SETUP   = 16'd5;
    localparam logic [15:0] RST_WRITE_ZERO    = 16'd80;
    localparam logic [15:0] RST_READ_LOW      = 16'd2;
    localparam logic [15:0] RST_READ_SAMPLE   = 16'd15;
    localparam logic [15:0] RST_READ_RECOVERY = 16'd15;
    localparam logic [15:0] RST_BYTE_GAP      = 16'd100;

    typedef struct packed {
        logic [15:0] reset_low_ticks;
        logic [7:0]  presence_polls;
        logic [15:0] write_setup_ticks;
        logic [15:0] write_zero_ticks;
        logic [15:0] read_low_ticks;
        logic [15:0] read_sample_ticks;
        logic [15:0] read_recovery_ticks;
        logic [15:0] byte_gap_ticks;
    } cfg_t;

    typedef struct packed {
        logic                 bus_ready;
        logic                 presence;
        logic [BYTE_BITS-1:0] read_data;
        logic                 done_res;
        logic                 busy_res;
        logic                 drive_low;
    } result_t;

endpackage
`default_nettype wire

// ----- rtl/owbm_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_cfg
// Timing register file behind the APB-style port.
// ----------------------------------------------------------------------------
module owbm_cfg (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [owbm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [owbm_pkg::CFG_DATA_W-1:0]     prdata,
    output owbm_pkg::cfg_t                           cfg
);

    owbm_pkg::cfg_t     cfg_reg;
    owbm_pkg::cfg_t     cfg_next;
    owbm_pkg::reg_idx_t sel;
    logic               wr_en;

    assign sel   = owbm_pkg::reg_idx_t'(paddr[owbm_pkg::CFG_ADDR_W-1:2]);
    assign wr_en = psel & penable & pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (sel)
                owbm_pkg::REG_RESET_LOW:      cfg_next.reset_low_ticks     = pwdata[15:0];
                owbm_pkg::REG_PRESENCE_POLLS: cfg_next.presence_polls      = pwdata[7:0];
                owbm_pkg::REG_WRITE_SETUP:    cfg_next.write_setup_ticks   = pwdata[15:0];
                owbm_pkg::REG_WRITE_ZERO:     cfg_next.write_zero_ticks    = pwdata[15:0];
                owbm_pkg::REG_READ_LOW:       cfg_next.read_low_ticks      = pwdata[15:0];
                owbm_pkg::REG_READ_SAMPLE:    cfg_next.read_sample_ticks   = pwdata[15:0];
                owbm_pkg::REG_READ_RECOVERY:  cfg_next.read_recovery_ticks = pwdata[15:0];
                owbm_pkg::REG_BYTE_GAP:       cfg_next.byte_gap_ticks      = pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low_ticks     <= owbm_pkg::RST_RESET_LOW;
            cfg_reg.presence_polls      <= owbm_pkg::RST_PRESENCE_POLL;
            cfg_reg.write_setup_ticks   <= owbm_pkg::RST_WRITE_SETUP;
            cfg_reg.write_zero_ticks    <= owbm_pkg::RST_WRITE_ZERO;
            cfg_reg.read_low_ticks      <= owbm_pkg::RST_READ_LOW;
            cfg_reg.read_sample_ticks   <= owbm_pkg::RST_READ_SAMPLE;
            cfg_reg.read_recovery_ticks <= owbm_pkg::RST_READ_RECOVERY;
            cfg_reg.byte_gap_ticks      <= owbm_pkg::RST_BYTE_GAP;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        prdata = '0;
        case (sel)
            owbm_pkg::REG_RESET_LOW:      prdata[15:0] = cfg_reg.reset_low_ticks;
            owbm_pkg::REG_PRESENCE_POLLS: prdata[7:0]  = cfg_reg.presence_polls;
            owbm_pkg::REG_WRITE_SETUP:    prdata[15:0] = cfg_reg.write_setup_ticks;
            owbm_pkg::REG_WRITE_ZERO:     prdata[15:0] = cfg_reg.write_zero_ticks;
            owbm_pkg::REG_READ_LOW:       prdata[15:0] = cfg_reg.read_low_ticks;
            owbm_pkg::REG_READ_SAMPLE:    prdata[15:0] = cfg_reg.read_sample_ticks;
            owbm_pkg::REG_READ_RECOVERY:  prdata[15:0] = cfg_reg.read_recovery_ticks;
            owbm_pkg::REG_BYTE_GAP:       prdata[15:0] = cfg_reg.byte_gap_ticks;
            default: ;
        endcase
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- rtl/owbm_engine.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// owbm_engine
// Command state and one-tick step: phase, tick counter, bit index, shifter.
// ----------------------------------------------------------------------------
module owbm_engine #(
    parameter int TICK_W = owbm_pkg::TICK_COUNT_WIDTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              step_en,
    input  wire owbm_pkg::op_t                     op,
    input  wire logic [owbm_pkg::BYTE_BITS-1:0]    write_byte,
    input  wire logic                              line_level,
    input  wire owbm_pkg::cfg_t                    cfg,
    output owbm_pkg::result_t                      result
);

    localparam int          BB   = owbm_pkg::BYTE_BITS;
    localparam int          IW   = owbm_pkg::BIT_IDX_W;
    localparam logic [32:0] TMAX = (33'd1 << TICK_W) - 33'd1;
    localparam logic [IW-1:0] LAST_BIT = IW'(BB - 1);

    typedef struct packed {
        owbm_pkg::phase_t ph;
        logic [IW-1:0]    idx;
        logic [BB-1:0]    sh;
        logic             fin;
        logic             rd_done;
    } wst_t;

    owbm_pkg::phase_t  phase_reg, phase_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [BB-1:0]     sh_reg, sh_next;
    logic [BB-1:0]     rres_reg, rres_next;
    logic              pres_reg, pres_next;
    logic              rdy_reg, rdy_next;

    // saturate a register value to the tick counter range
    function automatic logic [TICK_W-1:0] sat(input logic [15:0] v);
        logic [32:0] w;
        w = 33'(v);
        if (w > TMAX)
            return TMAX[TICK_W-1:0];
        return w[TICK_W-1:0];
    endfunction

    function automatic logic [TICK_W-1:0] period_of(input owbm_pkg::phase_t p,
                                                    input owbm_pkg::cfg_t c);
        logic [TICK_W-1:0] r;
        case (p)
            owbm_pkg::PH_RST_LOW:   r = sat(c.reset_low_ticks);
            owbm_pkg::PH_RST_POLL:  r = sat(16'(c.presence_polls));
            owbm_pkg::PH_WR_SETUP:  r = sat(c.write_setup_ticks);
            owbm_pkg::PH_WR_ZERO:   r = sat(c.write_zero_ticks);
            owbm_pkg::PH_WR_GAP:    r = sat(c.byte_gap_ticks);
            owbm_pkg::PH_RD_LOW:    r = sat(c.read_low_ticks);
            owbm_pkg::PH_RD_WAIT:   r = sat(c.read_sample_ticks);
            owbm_pkg::PH_RD_SAMPLE: r = TICK_W'(1);
            owbm_pkg::PH_RD_REC:    r = sat(c.read_recovery_ticks);
            default:                r = '0;
        endcase
        return r;
    endfunction

    // Entry functions: each lands on a phase of nonzero length or on idle.
    function automatic wst_t finish(input wst_t s);
        wst_t r;
        r     = s;
        r.ph  = owbm_pkg::PH_IDLE;
        r.fin = 1'b1;
        return r;
    endfunction

    function automatic wst_t gap_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.ph = owbm_pkg::PH_WR_GAP;
        if (c.byte_gap_ticks == '0)
            r = finish(s);
        return r;
    endfunction

    // zero-length set-up: run over one bits (and zero bits too when the
    // zero period is empty) up to the first slot that takes time
    function automatic wst_t setup_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t          r;
        logic          found;
        logic [IW-1:0] k;
        logic [IW:0]   rem;
        r     = s;
        r.ph  = owbm_pkg::PH_WR_SETUP;
        found = 1'b0;
        k     = '0;
        rem   = (IW+1)'(BB) - {1'b0, s.idx};
        if (c.write_setup_ticks == '0) begin
            if (c.write_zero_ticks != '0) begin
                for (int i = 0; i < BB; i++) begin
                    if (!found && ((IW+1)'(i) < rem) && !s.sh[i]) begin
                        found = 1'b1;
                        k     = IW'(i);
                    end
                end
            end
            if (found) begin
                r.ph  = owbm_pkg::PH_WR_ZERO;
                r.sh  = s.sh >> k;
                r.idx = s.idx + k;
            end else begin
                r.sh  = s.sh >> rem;
                r.idx = LAST_BIT;
                r     = gap_enter(r, c);
            end
        end
        return r;
    endfunction

    function automatic wst_t bit_done(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.sh = s.sh >> 1;
        if (s.idx == LAST_BIT) begin
            r = gap_enter(r, c);
        end else begin
            r.idx = s.idx + IW'(1);
            r     = setup_enter(r, c);
        end
        return r;
    endfunction

    function automatic wst_t zero_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.ph = owbm_pkg::PH_WR_ZERO;
        if (c.write_zero_ticks == '0)
            r = bit_done(s, c);
        return r;
    endfunction

    function automatic wst_t rd_low_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r = s;
        if (c.read_low_ticks != '0)
            r.ph = owbm_pkg::PH_RD_LOW;
        else if (c.read_sample_ticks != '0)
            r.ph = owbm_pkg::PH_RD_WAIT;
        else
            r.ph = owbm_pkg::PH_RD_SAMPLE;
        return r;
    endfunction

    function automatic wst_t rd_bit_end(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r = s;
        if (s.idx == LAST_BIT) begin
            r         = finish(s);
            r.rd_done = 1'b1;
        end else begin
            r.idx = s.idx + IW'(1);
            r     = rd_low_enter(r, c);
        end
        return r;
    endfunction

    function automatic wst_t rec_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.ph = owbm_pkg::PH_RD_REC;
        if (c.read_recovery_ticks == '0)
            r = rd_bit_end(s, c);
        return r;
    endfunction

    function automatic wst_t poll_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.ph = owbm_pkg::PH_RST_POLL;
        if (c.presence_polls == '0)
            r = finish(s);
        return r;
    endfunction

    function automatic wst_t rst_enter(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r    = s;
        r.ph = owbm_pkg::PH_RST_LOW;
        if (c.reset_low_ticks == '0)
            r = poll_enter(s, c);
        return r;
    endfunction

    // phase that follows once the current period has run out
    function automatic wst_t next_after(input wst_t s, input owbm_pkg::cfg_t c);
        wst_t r;
        r = s;
        case (s.ph)
            owbm_pkg::PH_RST_LOW:   r = poll_enter(s, c);
            owbm_pkg::PH_WR_SETUP:  r = s.sh[0] ? bit_done(s, c) : zero_enter(s, c);
            owbm_pkg::PH_WR_ZERO:   r = bit_done(s, c);
            owbm_pkg::PH_RD_LOW: begin
                r.ph = (c.read_sample_ticks != '0) ? owbm_pkg::PH_RD_WAIT
                                                   : owbm_pkg::PH_RD_SAMPLE;
            end
            owbm_pkg::PH_RD_WAIT:   r.ph = owbm_pkg::PH_RD_SAMPLE;
            owbm_pkg::PH_RD_SAMPLE: r = rec_enter(s, c);
            owbm_pkg::PH_RD_REC:    r = rd_bit_end(s, c);
            default:                r = finish(s);
        endcase
        return r;
    endfunction

    wst_t              s_cur, s_start, s_end;
    logic [TICK_W-1:0] tc_start, tc_dec;
    logic              start, drive;

    always_comb begin
        s_cur     = '{ph: phase_reg, idx: idx_reg, sh: sh_reg, fin: 1'b0, rd_done: 1'b0};
        start     = (phase_reg == owbm_pkg::PH_IDLE) && (op != owbm_pkg::OP_TICK);
        pres_next = pres_reg;
        rdy_next  = rdy_reg;
        rres_next = rres_reg;
        drive     = 1'b0;
        s_start   = s_cur;
        tc_start  = tick_reg;

        if (start) begin
            s_start.idx = '0;
            case (op)
                owbm_pkg::OP_RESET: begin
                    pres_next = 1'b0;
                    rdy_next  = 1'b0;
                    s_start   = rst_enter(s_start, cfg);
                end
                owbm_pkg::OP_WRITE: begin
                    s_start.sh = write_byte;
                    s_start    = setup_enter(s_start, cfg);
                end
                default: begin
                    s_start.sh = '0;
                    s_start    = rd_low_enter(s_start, cfg);
                end
            endcase
            tc_start = period_of(s_start.ph, cfg);
        end

        s_end     = s_start;
        tc_dec    = tc_start - TICK_W'(tc_start != '0);
        tick_next = tc_start;

        if (s_start.ph != owbm_pkg::PH_IDLE) begin
            drive = (s_start.ph == owbm_pkg::PH_RST_LOW)  ||
                    (s_start.ph == owbm_pkg::PH_WR_SETUP) ||
                    (s_start.ph == owbm_pkg::PH_WR_ZERO)  ||
                    (s_start.ph == owbm_pkg::PH_RD_LOW);
            if (s_start.ph == owbm_pkg::PH_RST_POLL) begin
                if (!line_level)
                    pres_next = 1'b1;
                if (tc_start == TICK_W'(1))
                    rdy_next = line_level;
            end
            if (s_start.ph == owbm_pkg::PH_RD_SAMPLE)
                s_end.sh = s_start.sh | (BB'(line_level) << s_start.idx);
            tick_next = tc_dec;
            if (tc_dec == '0) begin
                s_end     = next_after(s_end, cfg);
                tick_next = period_of(s_end.ph, cfg);
            end
        end

        if (s_end.rd_done)
            rres_next = s_end.sh;

        phase_next = s_end.ph;
        idx_next   = s_end.idx;
        sh_next    = s_end.sh;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= owbm_pkg::PH_IDLE;
            tick_reg  <= '0;
            idx_reg   <= '0;
            sh_reg    <= '0;
            rres_reg  <= '0;
            pres_reg  <= 1'b0;
            rdy_reg   <= 1'b0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            idx_reg   <= idx_next;
            sh_reg    <= sh_next;
            rres_reg  <= rres_next;
            pres_reg  <= pres_next;
            rdy_reg   <= rdy_next;
        end
    end

    always_comb begin
        result.drive_low = drive;
        result.busy_res  = (s_end.ph != owbm_pkg::PH_IDLE);
        result.done_res  = s_end.fin;
        result.read_data = rres_next;
        result.presence  = pres_next;
        result.bus_ready = rdy_next;
    end

endmodule
`default_nettype wire

// ----- rtl/onewire_bus_master.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// onewire_bus_master
// Ticked single-wire bus master: reset/presence, byte write, byte read.
// ----------------------------------------------------------------------------
// Every item on the input stream is one timing tick carrying the sampled bus
// level; a tick that arrives while the master is idle may also start a
// command (bus reset with presence polling, byte write or byte read, both
// LSB first). Every tick yields exactly one result item with the open-drain
// low request for that tick plus busy/done status, the last read byte and the
// presence flags. Throughput is one item per clock while the output is not
// stalled: the whole tick step runs in the logic between the state registers,
// so a new tick is taken every cycle unless m_tready holds back the result; a
// tick passes the input register, then the result register. Slot timing
// comes from eight tick-count registers on the APB-style port, reset values
// 100/40/5/80/2/15/15/100; a period set to zero is skipped. Program them only
// while no command is running.
// ----------------------------------------------------------------------------
module onewire_bus_master #(
    parameter int TICK_COUNT_WIDTH = owbm_pkg::TICK_COUNT_WIDTH
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input ticks
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [15:0]                         s_tdata,  // write_byte[7:0], line_level[8]
    input  wire logic [1:0]                          s_tuser,  // op[1:0]
    // result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // drive_low[0], busy_res[1], done_res[2], read_data[10:3], presence[11],
    // bus_ready[12]
    output logic [15:0]                              m_tdata,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [owbm_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [owbm_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic      [owbm_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    localparam int BB = owbm_pkg::BYTE_BITS;

    // input register
    logic             in_valid_reg;
    owbm_pkg::op_t    op_reg;
    logic [BB-1:0]    wbyte_reg;
    logic             line_reg;

    // result register
    logic             out_valid_reg;
    logic [15:0]      out_data_reg;

    logic              advance;   // result register can take a new item
    logic              step_en;   // tick in the input register is processed
    owbm_pkg::cfg_t    cfg;
    owbm_pkg::result_t result;

    assign pready   = 1'b1;
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    // input register frees up whenever its item moves on
    assign s_tready = !in_valid_reg || advance;

    owbm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    owbm_engine #(
        .TICK_W (TICK_COUNT_WIDTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (step_en),
        .op         (op_reg),
        .write_byte (wbyte_reg),
        .line_level (line_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= owbm_pkg::op_t'(s_tuser);
            wbyte_reg <= s_tdata[BB-1:0];
            line_reg  <= s_tdata[BB];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= {3'b000, result};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // a processed tick always lands in the result register
    a_step_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en |=> m_tvalid)
        else $error("processed tick produced no result item");

    // a finished command leaves the master idle
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[2] && m_tdata[1]))
        else $error("done and busy reported together");

    // the bus is only pulled low inside a command
    a_drive_in_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[1] || m_tdata[2]))
        else $error("bus driven low outside a command");
`endif

endmodule
`default_nettype wire
